@@ hw/rtl/ansi_escape_sequence_encoder_unit_macros.svh @@
// Assertion macros shared by the escape sequence encoder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ANSI_ESCAPE_SEQUENCE_ENCODER_UNIT_MACROS_SVH
`define ANSI_ESCAPE_SEQUENCE_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define AESE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define AESE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/aese_pkg.sv @@
// Package for the escape sequence encoder: command codes, sequencer states,
// the command descriptor and the fixed byte values. Depends on nothing.
`timescale 1ns / 1ps

package aese_pkg;

    // Command codes as carried on the input selector
    typedef enum logic [2:0] {
        CMD_MOVE       = 3'd0,
        CMD_ERASE_LINE = 3'd1,
        CMD_ERASE_PAGE = 3'd2,
        CMD_BEEP       = 3'd3,
        CMD_ATTR       = 3'd4
    } cmd_t;

    // Back-end sequencer states: idle plus one per emitted byte position
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ESC,
        ST_LBR,
        ST_ROW_H,
        ST_ROW_T,
        ST_ROW_U,
        ST_SEMI,
        ST_COL_H,
        ST_COL_T,
        ST_COL_U,
        ST_BOLD_0,
        ST_BOLD_1,
        ST_BOLD_SEP,
        ST_FG_3,
        ST_FG_D,
        ST_BG_SEP,
        ST_BG_4,
        ST_BG_D,
        ST_FINAL,
        ST_BEL
    } state_t;

    // Decimal digits of a value 1..255
    typedef struct packed {
        logic [1:0] hund;
        logic [3:0] tens;
        logic [3:0] units;
    } dec_t;

    // Classified command handed from front to back
    typedef struct packed {
        cmd_t       cmd;
        dec_t       row;
        dec_t       col;
        logic       bare;
        logic       bold;
        logic [2:0] fg;
        logic       has_bg;
        logic [2:0] bg;
    } desc_t;

    localparam int unsigned DESC_W = $bits(desc_t);

    // Fixed byte values
    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_BEL   = 8'h07;
    localparam logic [7:0] BYTE_LBR   = 8'h5B;
    localparam logic [7:0] BYTE_SEMI  = 8'h3B;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_ONE   = 8'h31;
    localparam logic [7:0] BYTE_THREE = 8'h33;
    localparam logic [7:0] BYTE_FOUR  = 8'h34;
    localparam logic [7:0] BYTE_CUP   = 8'h48;
    localparam logic [7:0] BYTE_EL    = 8'h4B;
    localparam logic [7:0] BYTE_ED    = 8'h4A;
    localparam logic [7:0] BYTE_SGR   = 8'h6D;

    // Attribute values that give a bare SGR reset
    localparam logic [7:0] ATTR_PLAIN    = 8'h70;
    localparam logic [7:0] ATTR_PLAIN_NB = 8'h78;

endpackage

@@ hw/rtl/ansi_escape_sequence_encoder_unit.sv @@
// A command passes the front stage, the queue, the sequencer and the output
// stage. The sequencer walks a command of n bytes (1 to 11), emitting one
// byte per cycle unless m_tready stalls the output, and passes through idle
// to take the next request from the queue; the front keeps accepting while
// the queue has room. Reset (aresetn low, synchronous) empties the front
// stage, the queue and the output stage and returns the sequencer to idle.
`timescale 1ns / 1ps

module ansi_escape_sequence_encoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row_index[7:0], column_index[15:8], attribute[23:16]
    input  logic [2:0]  s_tuser,   // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // char_code[7:0]
    output logic        m_tlast,
    output logic        m_tuser    // flush_request[0]
);

    logic            push_valid;
    logic            push_ready;
    aese_pkg::desc_t push_desc;
    logic            pop_valid;
    logic            pop_ready;
    aese_pkg::desc_t pop_desc;

    // Accept and classify commands
    aese_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser),
        .in_row     (s_tdata[7:0]),
        .in_col     (s_tdata[15:8]),
        .in_attr    (s_tdata[23:16]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    // Decouple front and back
    aese_queue #(
        .WIDTH (aese_pkg::DESC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_desc),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_desc)
    );

    // Emit the byte run
    aese_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_desc  (pop_desc),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_code  (m_tdata),
        .out_last  (m_tlast),
        .out_flush (m_tuser)
    );

endmodule

@@ hw/rtl/aese_front.sv @@
// Front end of the escape sequence encoder: accepts commands, classifies
// them and converts coordinates to decimal digits. Depends on aese_pkg.
`timescale 1ns / 1ps

module aese_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            in_func,
    input  logic [7:0]            in_row,
    input  logic [7:0]            in_col,
    input  logic [7:0]            in_attr,
    output logic                  push_valid,
    input  logic                  push_ready,
    output aese_pkg::desc_t       push_desc
);

    logic            front_valid_reg;
    logic            front_valid_next;
    aese_pkg::desc_t front_desc_reg;
    aese_pkg::desc_t front_desc_next;
    logic            cmd_known;
    logic            accept;

    // Coordinate plus one, saturating so that 255 and 254 both send 255
    function automatic logic [7:0] coord_plus_one(input logic [7:0] c);
        coord_plus_one = (c == 8'hFF) ? 8'hFF : c + 8'd1;
    endfunction

    // Split 1..255 into digits; tens by reciprocal multiply (valid below 1029)
    function automatic aese_pkg::dec_t to_decimal(input logic [7:0] v);
        aese_pkg::dec_t d;
        logic [7:0]     rem;
        logic [15:0]    prod;
        logic [7:0]     units;
        d.hund = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        rem    = v - ((v >= 8'd200) ? 8'd200 : ((v >= 8'd100) ? 8'd100 : 8'd0));
        prod   = 16'(rem) * 16'd205;
        d.tens = prod[14:11];
        units  = rem - 8'(d.tens) * 8'd10;
        d.units = units[3:0];
        to_decimal = d;
    endfunction

    // Accept when the stage is empty or drains this cycle
    assign in_ready   = !front_valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = front_valid_reg;
    assign push_desc  = front_desc_reg;

    // Classify the command and drop undefined codes
    always_comb begin
        cmd_known              = 1'b1;
        front_desc_next        = front_desc_reg;
        front_desc_next.cmd    = aese_pkg::CMD_MOVE;
        unique case (in_func)
            aese_pkg::CMD_MOVE:       front_desc_next.cmd = aese_pkg::CMD_MOVE;
            aese_pkg::CMD_ERASE_LINE: front_desc_next.cmd = aese_pkg::CMD_ERASE_LINE;
            aese_pkg::CMD_ERASE_PAGE: front_desc_next.cmd = aese_pkg::CMD_ERASE_PAGE;
            aese_pkg::CMD_BEEP:       front_desc_next.cmd = aese_pkg::CMD_BEEP;
            aese_pkg::CMD_ATTR:       front_desc_next.cmd = aese_pkg::CMD_ATTR;
            default:                  cmd_known = 1'b0;
        endcase
        front_desc_next.row    = to_decimal(coord_plus_one(in_row));
        front_desc_next.col    = to_decimal(coord_plus_one(in_col));
        front_desc_next.bare   = (in_attr == aese_pkg::ATTR_PLAIN) ||
                                 (in_attr == aese_pkg::ATTR_PLAIN_NB);
        front_desc_next.bold   = in_attr[7];
        front_desc_next.fg     = in_attr[6:4];
        front_desc_next.has_bg = !in_attr[3];
        front_desc_next.bg     = in_attr[2:0];
    end

    // Hold the stage until the queue takes it
    always_comb begin
        front_valid_next = front_valid_reg;
        if (accept) begin
            front_valid_next = cmd_known;
        end else if (push_ready) begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            front_desc_reg <= front_desc_next;
        end
    end

endmodule

@@ hw/rtl/aese_queue.sv @@
// Short register queue between front and back of the encoder.
// Depends on the assertion macro header only.
`timescale 1ns / 1ps
`include "ansi_escape_sequence_encoder_unit_macros.svh"

module aese_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers with wrap and track the fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    `AESE_ASSERT_SAME(a_no_pop_empty, aclk, aresetn, pop, count_reg != '0, "queue popped while empty")
    `AESE_ASSERT_NEXT(a_fill_tracks, aclk, aresetn, push && !pop, count_reg != '0, "queue count lost a push")

endmodule

@@ hw/rtl/aese_back.sv @@
// Back end of the encoder: walks one command descriptor byte by byte into
// a registered output stage. Depends on aese_pkg and the macro header.
`timescale 1ns / 1ps
`include "ansi_escape_sequence_encoder_unit_macros.svh"

module aese_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  aese_pkg::desc_t pop_desc,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_code,
    output logic            out_last,
    output logic            out_flush
);

    aese_pkg::state_t state_reg, state_next;
    aese_pkg::desc_t  desc_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_code_reg;
    logic             out_last_reg;
    logic             out_flush_reg;
    logic             out_load;
    logic             emit;
    logic [7:0]       byte_code;
    logic             byte_last;
    logic             byte_flush;
    aese_pkg::state_t row_first;
    aese_pkg::state_t col_first;

    assign out_load  = !out_valid_reg || out_ready;
    assign emit      = (state_reg != aese_pkg::ST_IDLE) && out_load;
    assign pop_ready = (state_reg == aese_pkg::ST_IDLE);

    assign out_valid = out_valid_reg;
    assign out_code  = out_code_reg;
    assign out_last  = out_last_reg;
    assign out_flush = out_flush_reg;

    // Skip leading zeros of each coordinate
    assign row_first = (desc_reg.row.hund != '0) ? aese_pkg::ST_ROW_H :
                       (desc_reg.row.tens != '0) ? aese_pkg::ST_ROW_T : aese_pkg::ST_ROW_U;
    assign col_first = (desc_reg.col.hund != '0) ? aese_pkg::ST_COL_H :
                       (desc_reg.col.tens != '0) ? aese_pkg::ST_COL_T : aese_pkg::ST_COL_U;

    // Next state: advance one byte per emitted result
    always_comb begin
        state_next = state_reg;
        if (state_reg == aese_pkg::ST_IDLE) begin
            if (pop_valid) begin
                state_next = (pop_desc.cmd == aese_pkg::CMD_BEEP) ? aese_pkg::ST_BEL
                                                                  : aese_pkg::ST_ESC;
            end
        end else if (out_load) begin
            unique case (state_reg)
                aese_pkg::ST_ESC:      state_next = aese_pkg::ST_LBR;
                aese_pkg::ST_LBR: begin
                    priority if (desc_reg.cmd == aese_pkg::CMD_MOVE) begin
                        state_next = row_first;
                    end else if (desc_reg.cmd == aese_pkg::CMD_ATTR && !desc_reg.bare) begin
                        state_next = desc_reg.bold ? aese_pkg::ST_BOLD_0 : aese_pkg::ST_FG_3;
                    end else begin
                        state_next = aese_pkg::ST_FINAL;
                    end
                end
                aese_pkg::ST_ROW_H:    state_next = aese_pkg::ST_ROW_T;
                aese_pkg::ST_ROW_T:    state_next = aese_pkg::ST_ROW_U;
                aese_pkg::ST_ROW_U:    state_next = aese_pkg::ST_SEMI;
                aese_pkg::ST_SEMI:     state_next = col_first;
                aese_pkg::ST_COL_H:    state_next = aese_pkg::ST_COL_T;
                aese_pkg::ST_COL_T:    state_next = aese_pkg::ST_COL_U;
                aese_pkg::ST_COL_U:    state_next = aese_pkg::ST_FINAL;
                aese_pkg::ST_BOLD_0:   state_next = aese_pkg::ST_BOLD_1;
                aese_pkg::ST_BOLD_1:   state_next = aese_pkg::ST_BOLD_SEP;
                aese_pkg::ST_BOLD_SEP: state_next = aese_pkg::ST_FG_3;
                aese_pkg::ST_FG_3:     state_next = aese_pkg::ST_FG_D;
                aese_pkg::ST_FG_D:     state_next = desc_reg.has_bg ? aese_pkg::ST_BG_SEP
                                                                    : aese_pkg::ST_FINAL;
                aese_pkg::ST_BG_SEP:   state_next = aese_pkg::ST_BG_4;
                aese_pkg::ST_BG_4:     state_next = aese_pkg::ST_BG_D;
                aese_pkg::ST_BG_D:     state_next = aese_pkg::ST_FINAL;
                aese_pkg::ST_FINAL:    state_next = aese_pkg::ST_IDLE;
                aese_pkg::ST_BEL:      state_next = aese_pkg::ST_IDLE;
                default:               state_next = aese_pkg::ST_IDLE;
            endcase
        end
    end

    // Outputs: the byte for the current position
    always_comb begin
        byte_last  = 1'b0;
        byte_flush = 1'b0;
        byte_code  = aese_pkg::BYTE_ESC;
        unique case (state_reg)
            aese_pkg::ST_ESC:      byte_code = aese_pkg::BYTE_ESC;
            aese_pkg::ST_LBR:      byte_code = aese_pkg::BYTE_LBR;
            aese_pkg::ST_ROW_H:    byte_code = aese_pkg::BYTE_ZERO | {6'd0, desc_reg.row.hund};
            aese_pkg::ST_ROW_T:    byte_code = aese_pkg::BYTE_ZERO | {4'd0, desc_reg.row.tens};
            aese_pkg::ST_ROW_U:    byte_code = aese_pkg::BYTE_ZERO | {4'd0, desc_reg.row.units};
            aese_pkg::ST_SEMI:     byte_code = aese_pkg::BYTE_SEMI;
            aese_pkg::ST_COL_H:    byte_code = aese_pkg::BYTE_ZERO | {6'd0, desc_reg.col.hund};
            aese_pkg::ST_COL_T:    byte_code = aese_pkg::BYTE_ZERO | {4'd0, desc_reg.col.tens};
            aese_pkg::ST_COL_U:    byte_code = aese_pkg::BYTE_ZERO | {4'd0, desc_reg.col.units};
            aese_pkg::ST_BOLD_0:   byte_code = aese_pkg::BYTE_ZERO;
            aese_pkg::ST_BOLD_1:   byte_code = aese_pkg::BYTE_ONE;
            aese_pkg::ST_BOLD_SEP: byte_code = aese_pkg::BYTE_SEMI;
            aese_pkg::ST_FG_3:     byte_code = aese_pkg::BYTE_THREE;
            aese_pkg::ST_FG_D:     byte_code = aese_pkg::BYTE_ZERO | {5'd0, desc_reg.fg};
            aese_pkg::ST_BG_SEP:   byte_code = aese_pkg::BYTE_SEMI;
            aese_pkg::ST_BG_4:     byte_code = aese_pkg::BYTE_FOUR;
            aese_pkg::ST_BG_D:     byte_code = aese_pkg::BYTE_ZERO | {5'd0, desc_reg.bg};
            aese_pkg::ST_FINAL: begin
                byte_last = 1'b1;
                unique case (desc_reg.cmd)
                    aese_pkg::CMD_MOVE:       byte_code = aese_pkg::BYTE_CUP;
                    aese_pkg::CMD_ERASE_LINE: byte_code = aese_pkg::BYTE_EL;
                    aese_pkg::CMD_ERASE_PAGE: byte_code = aese_pkg::BYTE_ED;
                    default:                  byte_code = aese_pkg::BYTE_SGR;
                endcase
            end
            aese_pkg::ST_BEL: begin
                byte_code  = aese_pkg::BYTE_BEL;
                byte_last  = 1'b1;
                byte_flush = 1'b1;
            end
            default:               byte_code = aese_pkg::BYTE_ESC;
        endcase
    end

    // Output stage: load a new byte or drop the taken one
    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= aese_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == aese_pkg::ST_IDLE && pop_valid) begin
            desc_reg <= pop_desc;
        end
        if (emit) begin
            out_code_reg  <= byte_code;
            out_last_reg  <= byte_last;
            out_flush_reg <= byte_flush;
        end
    end

    `AESE_ASSERT_SAME(a_flush_ends_run, aclk, aresetn, out_valid && out_flush, out_last, "flush byte not last of run")
    `AESE_ASSERT_NEXT(a_pop_starts_run, aclk, aresetn, pop_valid && pop_ready, state_reg != aese_pkg::ST_IDLE, "popped request not started")

endmodule
